@@ rtl/odcd_pkg.sv @@
// Package for the OLED command/data decoder: command codes, item kinds and
// the queue item type shared by the front end, queue and back end.
// No dependencies.
package odcd_pkg;

    localparam int COLUMN_PAIRS_DEFAULT = 128;
    localparam int ROWS_DEFAULT         = 64;

    localparam int BYTE_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 6;
    localparam int ADDR_W = 13;
    localparam int PIX_W  = 4;
    localparam int OUT_DATA_W = 24;

    localparam logic [BYTE_W-1:0] CMD_LOW_COL      = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_LOW_COL_END  = 8'h0F;
    localparam logic [BYTE_W-1:0] CMD_HIGH_COL     = 8'h10;
    localparam logic [BYTE_W-1:0] CMD_HIGH_COL_END = 8'h1F;
    localparam logic [BYTE_W-1:0] CMD_ROW_ADDR     = 8'hB0;
    localparam logic [BYTE_W-1:0] CMD_CONTRAST     = 8'h81;
    localparam logic [BYTE_W-1:0] CMD_DISP_OFFSET  = 8'hD3;
    localparam logic [BYTE_W-1:0] CMD_CLOCK_DIV    = 8'hD5;
    localparam logic [BYTE_W-1:0] CMD_PRECHARGE    = 8'hD9;
    localparam logic [BYTE_W-1:0] CMD_VCOM_LEVEL   = 8'hDB;
    localparam logic [BYTE_W-1:0] CMD_VSEG_LEVEL   = 8'hDC;
    localparam logic [BYTE_W-1:0] CMD_DISP_OFF     = 8'hAE;
    localparam logic [BYTE_W-1:0] CMD_DISP_ON      = 8'hAF;

    typedef enum logic [2:0] {
        KIND_DATA,
        KIND_LOW_COL,
        KIND_HIGH_COL,
        KIND_ARM_ROW,
        KIND_ARM_SKIP,
        KIND_DISP_ON,
        KIND_DISP_OFF,
        KIND_OTHER
    } odcd_kind_t;

    typedef struct packed {
        odcd_kind_t              kind;
        logic [BYTE_W-1:0]       value;
    } odcd_item_t;

endpackage

@@ rtl/odcd_front.sv @@
// Front end of the OLED command/data decoder: classifies each incoming byte
// into an item kind for the back end. Depends on odcd_pkg.
module odcd_front (
    input  logic                          func,
    input  logic [odcd_pkg::BYTE_W-1:0]   byte_value,
    output odcd_pkg::odcd_item_t          item
);
    import odcd_pkg::*;

    odcd_kind_t cmd_kind;

    always_comb
    begin
        unique case (byte_value) inside
            [CMD_LOW_COL:CMD_LOW_COL_END]:   cmd_kind = KIND_LOW_COL;
            [CMD_HIGH_COL:CMD_HIGH_COL_END]: cmd_kind = KIND_HIGH_COL;
            CMD_ROW_ADDR:                    cmd_kind = KIND_ARM_ROW;
            CMD_CONTRAST, CMD_DISP_OFFSET, CMD_CLOCK_DIV,
            CMD_PRECHARGE, CMD_VCOM_LEVEL, CMD_VSEG_LEVEL:
                                             cmd_kind = KIND_ARM_SKIP;
            CMD_DISP_ON:                     cmd_kind = KIND_DISP_ON;
            CMD_DISP_OFF:                    cmd_kind = KIND_DISP_OFF;
            default:                         cmd_kind = KIND_OTHER;
        endcase
    end

    assign item.kind  = func ? cmd_kind : KIND_DATA;
    assign item.value = byte_value;

endmodule

@@ rtl/odcd_queue.sv @@
// Two-entry queue between the front and back ends of the OLED command/data
// decoder. Generic in width; no package dependency.
module odcd_queue #(
    parameter int WIDTH = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue occupancy out of range");

    // Pointers differ exactly when one entry is held.
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with occupancy");

endmodule

@@ rtl/odcd_back.sv @@
// Back end of the OLED command/data decoder: holds the address and display
// state, executes queued items and registers one result beat per item.
// Depends on odcd_pkg.
module odcd_back #(
    parameter int COLUMN_PAIRS = odcd_pkg::COLUMN_PAIRS_DEFAULT,
    parameter int ROWS         = odcd_pkg::ROWS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  odcd_pkg::odcd_item_t         item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         write_enable,
    output logic [odcd_pkg::ADDR_W-1:0]  pixel_pair_address,
    output logic [odcd_pkg::PIX_W-1:0]   left_pixel,
    output logic [odcd_pkg::PIX_W-1:0]   right_pixel,
    output logic                         display_enabled
);
    import odcd_pkg::*;

    localparam logic [COL_W-1:0]  ColLast   = COL_W'(COLUMN_PAIRS - 1);
    localparam logic [ROW_W-1:0]  RowLast   = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] RowStride = ADDR_W'(COLUMN_PAIRS);

    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic              pending_reg;
    logic              pending_next;
    logic              prev_row_reg;
    logic              prev_row_next;
    logic              disp_reg;
    logic              disp_next;

    logic              valid_reg;
    logic              valid_next;
    logic              we_reg;
    logic              we_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic [PIX_W-1:0]  left_reg;
    logic [PIX_W-1:0]  left_next;
    logic [PIX_W-1:0]  right_reg;
    logic [PIX_W-1:0]  right_next;
    logic              disp_out_reg;
    logic              disp_out_next;

    logic              pop;

    assign item_ready = !valid_reg || out_ready;
    assign pop        = item_valid && item_ready;

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        pending_next  = pending_reg;
        prev_row_next = prev_row_reg;
        disp_next     = disp_reg;
        valid_next    = valid_reg && !out_ready;
        we_next       = we_reg;
        addr_next     = addr_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        disp_out_next = disp_out_reg;

        if (pop)
        begin
            valid_next = 1'b1;
            we_next    = 1'b0;
            addr_next  = '0;
            left_next  = '0;
            right_next = '0;
            if (item.kind == KIND_DATA)
            begin
                we_next    = 1'b1;
                addr_next  = ADDR_W'({{(ADDR_W-ROW_W){1'b0}}, row_reg} * RowStride)
                             + ADDR_W'(col_reg);
                left_next  = item.value[2*PIX_W-1:PIX_W];
                right_next = item.value[PIX_W-1:0];
                if (col_reg >= ColLast)
                begin
                    col_next = '0;
                    row_next = (row_reg >= RowLast) ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            else if (pending_reg)
            begin
                // This command byte is the argument of the previous command.
                if (prev_row_reg)
                begin
                    row_next = item.value[ROW_W-1:0];
                end
                pending_next = 1'b0;
            end
            else
            begin
                prev_row_next = (item.kind == KIND_ARM_ROW);
                case (item.kind) inside
                    KIND_LOW_COL:  col_next[3:0] = item.value[3:0];
                    KIND_HIGH_COL: col_next[COL_W-1:4] = item.value[COL_W-5:0];
                    KIND_ARM_ROW, KIND_ARM_SKIP: pending_next = 1'b1;
                    KIND_DISP_ON:  disp_next = 1'b1;
                    KIND_DISP_OFF: disp_next = 1'b0;
                    default:       ;
                endcase
            end
            disp_out_next = disp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            pending_reg  <= 1'b0;
            prev_row_reg <= 1'b0;
            disp_reg     <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            pending_reg  <= pending_next;
            prev_row_reg <= prev_row_next;
            disp_reg     <= disp_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        we_reg       <= we_next;
        addr_reg     <= addr_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        disp_out_reg <= disp_out_next;
    end

    assign out_valid          = valid_reg;
    assign write_enable       = we_reg;
    assign pixel_pair_address = addr_reg;
    assign left_pixel         = left_reg;
    assign right_pixel        = right_reg;
    assign display_enabled    = disp_out_reg;

    a_data_writes: assert property (@(posedge clk) disable iff (!rst_n)
        pop && item.kind == KIND_DATA |=> valid_reg && we_reg)
        else $error("data item did not produce a write beat");

    a_stall_holds_addr: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> $stable(col_reg) && $stable(row_reg))
        else $error("address moved while the result beat was stalled");

    a_cmd_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        pop && item.kind != KIND_DATA |=> !we_reg && addr_reg == '0)
        else $error("command item produced a write");

endmodule

@@ rtl/oled_command_data_decoder.sv @@
// Top level of the OLED command/data decoder: front-end classifier, a
// two-entry queue and the executing back end. Depends on odcd_pkg,
// odcd_front, odcd_queue and odcd_back.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata: byte_value; tuser: func (1 = command)
//  m_axis    out        tdata: address, left and right pixel, display on;
//                       tuser: write_enable
//
// One byte is accepted every clock while m_axis is not stalled; the result beat
// for each byte passes through the queue register and then the output register.
// Reset clears the column, row, argument and display state and empties the
// queue and output register. When m_axis stalls, the queue fills both its
// entries before s_axis_tready falls.
module oled_command_data_decoder #(
    parameter int COLUMN_PAIRS = odcd_pkg::COLUMN_PAIRS_DEFAULT,
    parameter int ROWS         = odcd_pkg::ROWS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [odcd_pkg::BYTE_W-1:0]      s_axis_tdata,  // [7:0] byte_value
    input  logic                             s_axis_tuser,  // [0] func
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [12:0] pixel_pair_address, [16:13] left_pixel, [20:17] right_pixel,
    // [21] display_enabled, [23:22] zero
    output logic [odcd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tuser   // [0] write_enable
);
    import odcd_pkg::*;

    odcd_item_t        front_item;
    odcd_item_t        queue_item;
    logic              queue_valid;
    logic              queue_ready;
    logic              write_enable;
    logic [ADDR_W-1:0] pixel_pair_address;
    logic [PIX_W-1:0]  left_pixel;
    logic [PIX_W-1:0]  right_pixel;
    logic              display_enabled;

    odcd_front u_front (
        .func       (s_axis_tuser),
        .byte_value (s_axis_tdata),
        .item       (front_item)
    );

    odcd_queue #(
        .WIDTH ($bits(odcd_item_t))
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_data  (queue_item)
    );

    odcd_back #(
        .COLUMN_PAIRS (COLUMN_PAIRS),
        .ROWS         (ROWS)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .item_valid         (queue_valid),
        .item_ready         (queue_ready),
        .item               (queue_item),
        .out_valid          (m_axis_tvalid),
        .out_ready          (m_axis_tready),
        .write_enable       (write_enable),
        .pixel_pair_address (pixel_pair_address),
        .left_pixel         (left_pixel),
        .right_pixel        (right_pixel),
        .display_enabled    (display_enabled)
    );

    assign m_axis_tuser = write_enable;
    assign m_axis_tdata = {2'b00, display_enabled, right_pixel, left_pixel,
                           pixel_pair_address};

endmodule

@@ tb/sv/tb.sv @@
// Testbench for oled_command_data_decoder: directed and random command/data bytes
// with random idling on both streams and one long output stall. A scoreboard class
// predicts each result beat in order. Depends on odcd_pkg and the decoder RTL only.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import odcd_pkg::*;

    localparam int COLUMN_PAIRS = COLUMN_PAIRS_DEFAULT;
    localparam int ROWS         = ROWS_DEFAULT;

    localparam logic FUNC_DATA    = 1'b0;
    localparam logic FUNC_COMMAND = 1'b1;

    localparam int RANDOM_BYTES   = 600;
    localparam int MAX_GAP        = 16;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AT_BEAT   = 150;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int TAIL_CYCLES    = 20;
    localparam int REPORT_LIMIT   = 10;

    // Commands that take one argument byte.
    localparam logic [BYTE_W-1:0] ARG_COMMANDS [7] = '{CMD_ROW_ADDR, CMD_CONTRAST,
        CMD_DISP_OFFSET, CMD_CLOCK_DIV, CMD_PRECHARGE, CMD_VCOM_LEVEL, CMD_VSEG_LEVEL};

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] address;
        logic [PIX_W-1:0]  left_pixel;
        logic [PIX_W-1:0]  right_pixel;
        logic              panel_lit;
    } pixel_beat_t;

    class pixel_write_scoreboard;
        pixel_beat_t       expected_beats[$];
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic              arg_pending;
        logic [BYTE_W-1:0] last_command;
        logic              panel_lit;
        int                mismatches;

        function new();
            column       = '0;
            row          = '0;
            arg_pending  = 1'b0;
            last_command = '0;
            panel_lit    = 1'b0;
            mismatches   = 0;
        endfunction

        function void note_byte(logic is_command, logic [BYTE_W-1:0] value);
            pixel_beat_t beat;
            beat = '0;
            if (is_command)
            begin
                if (arg_pending)
                begin
                    // The argument leaves the remembered command untouched.
                    if (last_command == CMD_ROW_ADDR)
                        row = value[ROW_W-1:0];
                    arg_pending = 1'b0;
                end
                else
                begin
                    if (value[7:4] == CMD_LOW_COL[7:4])
                        column = {column[6:4], value[3:0]};
                    else if (value[7:4] == CMD_HIGH_COL[7:4])
                        column = {value[2:0], column[3:0]};
                    else
                    begin
                        case (value) inside
                            CMD_ROW_ADDR, CMD_CONTRAST, CMD_DISP_OFFSET, CMD_CLOCK_DIV,
                            CMD_PRECHARGE, CMD_VCOM_LEVEL, CMD_VSEG_LEVEL:
                                arg_pending = 1'b1;
                            CMD_DISP_ON:  panel_lit = 1'b1;
                            CMD_DISP_OFF: panel_lit = 1'b0;
                            default: ;
                        endcase
                    end
                    last_command = value;
                end
            end
            else
            begin
                beat.write_enable = 1'b1;
                beat.address      = ADDR_W'(int'(row) * COLUMN_PAIRS + int'(column));
                beat.left_pixel   = value[7:4];
                beat.right_pixel  = value[3:0];
                if (int'(column) >= COLUMN_PAIRS - 1)
                begin
                    column = '0;
                    if (int'(row) >= ROWS - 1)
                        row = '0;
                    else
                        row = row + 1'b1;
                end
                else
                    column = column + 1'b1;
            end
            beat.panel_lit = panel_lit;
            expected_beats.push_back(beat);
        endfunction

        function void check_beat(logic [OUT_DATA_W-1:0] data, logic user);
            pixel_beat_t want;
            pixel_beat_t got;
            got = {user, data[12:0], data[16:13], data[20:17], data[21]};
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result beat: we=%0b addr=%0d l=%0h r=%0h on=%0b",
                             got.write_enable, got.address, got.left_pixel,
                             got.right_pixel, got.panel_lit);
                return;
            end
            want = expected_beats.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("wrong beat: exp %0b/%0d/%0h/%0h/%0b got %0b/%0d/%0h/%0h/%0b",
                             want.write_enable, want.address, want.left_pixel,
                             want.right_pixel, want.panel_lit,
                             got.write_enable, got.address, got.left_pixel,
                             got.right_pixel, got.panel_lit);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    pixel_write_scoreboard decoder_sb;
    int  bytes_sent;
    int  beats_seen;
    logic tx_no_idle;
    logic rx_no_idle;

    oled_command_data_decoder #(
        .COLUMN_PAIRS (COLUMN_PAIRS),
        .ROWS         (ROWS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Offers one byte, possibly after an idle gap, and waits until it is accepted.
    task automatic send_byte(input logic is_command, input logic [BYTE_W-1:0] value);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= is_command;
        s_axis_tdata  <= value;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        decoder_sb.note_byte(is_command, value);
        bytes_sent++;
        if ($urandom_range(0, 39) == 0)
            tx_no_idle = ~tx_no_idle;
    endtask

    function automatic logic [BYTE_W-1:0] any_arg_command();
        return ARG_COMMANDS[$urandom_range(0, 6)];
    endfunction

    // Mostly well-formed command sequences with random content, plus noise.
    task automatic send_random_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            send_byte(FUNC_DATA, BYTE_W'($urandom));
        else if (pick < 60)
        begin
            send_byte(FUNC_COMMAND, CMD_ROW_ADDR);
            send_byte(FUNC_COMMAND, BYTE_W'($urandom));
        end
        else if (pick < 68)
        begin
            send_byte(FUNC_COMMAND, any_arg_command());
            send_byte(FUNC_COMMAND, BYTE_W'($urandom));
        end
        else if (pick < 78)
        begin
            send_byte(FUNC_COMMAND, CMD_LOW_COL | BYTE_W'($urandom_range(0, 15)));
            send_byte(FUNC_COMMAND, CMD_HIGH_COL | BYTE_W'($urandom_range(0, 15)));
        end
        else if (pick < 84)
            send_byte(FUNC_COMMAND, ($urandom_range(0, 1) == 1) ? CMD_DISP_ON : CMD_DISP_OFF);
        else if (pick < 92)
            send_byte(FUNC_COMMAND, BYTE_W'($urandom));
        else
        begin
            // Data written while an argument is still outstanding.
            send_byte(FUNC_COMMAND, any_arg_command());
            repeat ($urandom_range(1, 3))
                send_byte(FUNC_DATA, BYTE_W'($urandom));
            send_byte(FUNC_COMMAND, BYTE_W'($urandom));
        end
    endtask

    task automatic send_directed();
        send_byte(FUNC_COMMAND, CMD_DISP_ON);
        send_byte(FUNC_DATA, 8'h00);
        send_byte(FUNC_DATA, 8'hFF);
        // Highest column the nibbles can reach, then a write that wraps it.
        send_byte(FUNC_COMMAND, CMD_LOW_COL_END);
        send_byte(FUNC_COMMAND, CMD_HIGH_COL_END);
        send_byte(FUNC_DATA, 8'hA5);
        // Last row and last column: the write wraps both back to zero.
        send_byte(FUNC_COMMAND, CMD_ROW_ADDR);
        send_byte(FUNC_COMMAND, 8'hFF);
        send_byte(FUNC_COMMAND, CMD_HIGH_COL_END);
        send_byte(FUNC_COMMAND, CMD_LOW_COL_END);
        send_byte(FUNC_DATA, 8'h5A);
        send_byte(FUNC_DATA, 8'h3C);
        // Arguments are swallowed, even when they look like commands.
        send_byte(FUNC_COMMAND, CMD_CONTRAST);
        send_byte(FUNC_COMMAND, CMD_ROW_ADDR);
        send_byte(FUNC_COMMAND, CMD_DISP_OFFSET);
        send_byte(FUNC_DATA, 8'h11);
        send_byte(FUNC_COMMAND, 8'h40);
        send_byte(FUNC_COMMAND, CMD_CLOCK_DIV);
        send_byte(FUNC_COMMAND, CMD_DISP_OFF);
        send_byte(FUNC_COMMAND, CMD_PRECHARGE);
        send_byte(FUNC_COMMAND, CMD_LOW_COL);
        send_byte(FUNC_COMMAND, CMD_VCOM_LEVEL);
        send_byte(FUNC_COMMAND, CMD_HIGH_COL);
        send_byte(FUNC_COMMAND, CMD_VSEG_LEVEL);
        send_byte(FUNC_COMMAND, CMD_DISP_ON);
        send_byte(FUNC_COMMAND, CMD_DISP_OFF);
        send_byte(FUNC_COMMAND, 8'hA0);
        send_byte(FUNC_DATA, 8'hC3);
    endtask

    // Receiver: random stalls per beat, stall-free stretches and one long hold-off.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (beats_seen == HOLD_AT_BEAT)
                gap = LONG_HOLD;
            else
                gap = rx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            decoder_sb.check_beat(m_axis_tdata, m_axis_tuser);
            beats_seen++;
            if ($urandom_range(0, 39) == 0)
                rx_no_idle = ~rx_no_idle;
        end
    end

    initial
    begin
        int waited;
        decoder_sb    = new();
        bytes_sent    = 0;
        beats_seen    = 0;
        tx_no_idle    = 1'b0;
        rx_no_idle    = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        while (bytes_sent < RANDOM_BYTES + 28)
            send_random_sequence();
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (decoder_sb.expected_beats.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (decoder_sb.mismatches == 0 && decoder_sb.expected_beats.size() == 0)
            $display("oled_command_data_decoder: match");
        else
            $display("oled_command_data_decoder: mismatch");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("oled_command_data_decoder: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/odcd_pkg.sv
rtl/odcd_front.sv
rtl/odcd_queue.sv
rtl/odcd_back.sv
rtl/oled_command_data_decoder.sv
tb/sv/tb.sv
